// File: hdl/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
// No dependencies; every other file in hdl/ uses this package.
package i2cm_pkg;

  localparam int MAX_READ_LEN_DEF = 16;

  localparam int DEV_ADDR_W = 7;
  localparam int TIMEOUT_W  = 8;
  localparam int BYTE_W     = 8;
  localparam int RD_LEN_W   = 5;
  localparam int CFG_DATA_W = 8;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'd104;
  localparam logic [TIMEOUT_W-1:0]  ACK_TIMEOUT_RESET = 8'd250;

  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_ACK_TIMEOUT    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DEV_ADDR_W-1:0] device_address;
    logic [TIMEOUT_W-1:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic                cmd_valid;
    logic                req_type;
    logic [BYTE_W-1:0]   reg_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic [RD_LEN_W-1:0] rd_len;
    logic                sda_in;
  } in_word_t;

  typedef struct packed {
    logic              scl;
    logic              sda_low;
    logic [BYTE_W-1:0] rd_data;
    logic              rd_valid;
    logic              rd_last;
    logic              done_res;
    logic              error;
    logic              busy_res;
  } out_word_t;

endpackage

// File: hdl/i2cm_if.sv
// Valid/ready channel interfaces for tick words in and bus result words out.
// Depends on i2cm_pkg for field widths.
interface i2cm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd_valid;
  logic                          req_type;
  logic [i2cm_pkg::BYTE_W-1:0]   reg_addr;
  logic [i2cm_pkg::BYTE_W-1:0]   wr_data;
  logic [i2cm_pkg::RD_LEN_W-1:0] rd_len;
  logic                          sda_in;

  modport source (output valid, cmd_valid, req_type, reg_addr, wr_data, rd_len, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, req_type, reg_addr, wr_data, rd_len, sda_in,
                output ready);
endinterface

interface i2cm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        scl;
  logic                        sda_low;
  logic [i2cm_pkg::BYTE_W-1:0] rd_data;
  logic                        rd_valid;
  logic                        rd_last;
  logic                        done_res;
  logic                        error;
  logic                        busy_res;

  modport source (output valid, scl, sda_low, rd_data, rd_valid, rd_last, done_res, error,
                  busy_res, input ready);
  modport sink (input valid, scl, sda_low, rd_data, rd_valid, rd_last, done_res, error,
                busy_res, output ready);
endinterface

// File: hdl/i2cm_cfg.sv
// Configuration registers: target address and acknowledge timeout.
// Depends on i2cm_pkg.
module i2cm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  i2cm_pkg::cfg_idx_t              cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data,
  output i2cm_pkg::cfg_t                  cfg
);
  import i2cm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEV_ADDR_RESET;
      cfg.ack_timeout    <= ACK_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[DEV_ADDR_W-1:0];
        CFG_ACK_TIMEOUT:    cfg.ack_timeout    <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/i2cm_seq.sv
// Bus sequencer: one phase step per accepted tick, producing that tick's line levels.
// Depends on i2cm_pkg.
module i2cm_seq #(
  parameter int MaxReadLen = i2cm_pkg::MAX_READ_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cm_pkg::in_word_t  tick,
  input  i2cm_pkg::cfg_t      cfg,
  output i2cm_pkg::out_word_t res
);
  import i2cm_pkg::*;

  localparam int BL_W = $clog2(MaxReadLen + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_TXL, S_TXH, S_AKL, S_AKH, S_RS1, S_RS2, S_RS3,
    S_RXL, S_RXH, S_MAL, S_MAH, S_SP1, S_SP2, S_SP3, S_SE1, S_SE2, S_SE3
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDRW, STG_REG, STG_DATA, STG_ADDRR
  } stage_t;

  phase_t              phase, phase_next;
  stage_t              stage, stage_next;
  logic [2:0]          bit_count, bit_count_next;
  logic [BYTE_W-1:0]   shift_reg, shift_reg_next;
  logic [BL_W-1:0]     bytes_left, bytes_left_next;
  logic [TIMEOUT_W-1:0] ack_cnt, ack_cnt_next;
  logic                held_req_type, held_req_type_next;
  logic [BYTE_W-1:0]   held_register, held_register_next;
  logic [BYTE_W-1:0]   held_write_data, held_write_data_next;

  logic                load;
  stage_t              load_stage;
  logic [BYTE_W-1:0]   load_byte;
  logic [RD_LEN_W-1:0] len_min;
  logic [BL_W-1:0]     len_sat;
  logic [TIMEOUT_W-1:0] ack_inc;
  logic [BYTE_W-1:0]   rx_shift;

  always_comb begin
    len_min = (tick.rd_len == '0) ? RD_LEN_W'(1) : tick.rd_len;
    if (32'(len_min) > MaxReadLen) len_sat = BL_W'(MaxReadLen);
    else                           len_sat = BL_W'(len_min);
    ack_inc  = (ack_cnt != '1) ? ack_cnt + 1'b1 : ack_cnt;
    rx_shift = {shift_reg[BYTE_W-2:0], tick.sda_in};
  end

  always_comb begin
    unique case (load_stage)
      STG_ADDRW: load_byte = {cfg.device_address, 1'b0};
      STG_REG:   load_byte = held_register;
      STG_DATA:  load_byte = held_write_data;
      STG_ADDRR: load_byte = {cfg.device_address, 1'b1};
      default:   load_byte = '0;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    stage_next           = stage;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    bytes_left_next      = bytes_left;
    ack_cnt_next         = ack_cnt;
    held_req_type_next   = held_req_type;
    held_register_next   = held_register;
    held_write_data_next = held_write_data;
    load       = 1'b0;
    load_stage = STG_ADDRW;
    res        = '0;
    res.scl    = 1'b1;

    unique case (phase)
      S_IDLE: begin
        if (tick.cmd_valid) begin
          held_req_type_next   = tick.req_type;
          held_register_next   = tick.reg_addr;
          held_write_data_next = tick.wr_data;
          bytes_left_next      = len_sat;
          phase_next           = S_START;
        end
      end
      S_START: begin
        res.sda_low = 1'b1;
        load        = 1'b1;
        load_stage  = STG_ADDRW;
      end
      S_TXL: begin
        res.scl     = 1'b0;
        res.sda_low = ~shift_reg[BYTE_W-1];
        phase_next  = S_TXH;
      end
      S_TXH: begin
        res.sda_low    = ~shift_reg[BYTE_W-1];
        shift_reg_next = {shift_reg[BYTE_W-2:0], 1'b0};
        if (bit_count == 3'd7) begin
          bit_count_next = '0;
          phase_next     = S_AKL;
        end else begin
          bit_count_next = bit_count + 1'b1;
          phase_next     = S_TXL;
        end
      end
      S_AKL: begin
        res.scl      = 1'b0;
        ack_cnt_next = '0;
        phase_next   = S_AKH;
      end
      S_AKH: begin
        if (!tick.sda_in) begin
          unique case (stage)
            STG_ADDRW: begin
              load       = 1'b1;
              load_stage = STG_REG;
            end
            STG_REG: begin
              if (held_req_type) begin
                phase_next = S_RS1;
              end else begin
                load       = 1'b1;
                load_stage = STG_DATA;
              end
            end
            STG_DATA: phase_next = S_SP1;
            STG_ADDRR: begin
              shift_reg_next = '0;
              bit_count_next = '0;
              phase_next     = S_RXL;
            end
            default: phase_next = S_IDLE;
          endcase
        end else begin
          ack_cnt_next = ack_inc;
          if (ack_inc >= cfg.ack_timeout) phase_next = S_SE1;
        end
      end
      S_RS1: begin
        res.scl    = 1'b0;
        phase_next = S_RS2;
      end
      S_RS2: phase_next = S_RS3;
      S_RS3: begin
        res.sda_low = 1'b1;
        load        = 1'b1;
        load_stage  = STG_ADDRR;
      end
      S_RXL: begin
        res.scl    = 1'b0;
        phase_next = S_RXH;
      end
      S_RXH: begin
        shift_reg_next = rx_shift;
        if (bit_count == 3'd7) begin
          bit_count_next = '0;
          res.rd_valid   = 1'b1;
          res.rd_data    = rx_shift;
          res.rd_last    = (bytes_left <= BL_W'(1));
          phase_next     = S_MAL;
        end else begin
          bit_count_next = bit_count + 1'b1;
          phase_next     = S_RXL;
        end
      end
      S_MAL: begin
        res.scl     = 1'b0;
        res.sda_low = (bytes_left > BL_W'(1));
        phase_next  = S_MAH;
      end
      S_MAH: begin
        res.sda_low = (bytes_left > BL_W'(1));
        if (bytes_left > BL_W'(1)) begin
          bytes_left_next = bytes_left - 1'b1;
          phase_next      = S_RXL;
        end else begin
          bytes_left_next = '0;
          phase_next      = S_SP1;
        end
      end
      S_SP1, S_SE1: begin
        res.scl     = 1'b0;
        res.sda_low = 1'b1;
        phase_next  = (phase == S_SP1) ? S_SP2 : S_SE2;
      end
      S_SP2, S_SE2: begin
        res.sda_low = 1'b1;
        phase_next  = (phase == S_SP2) ? S_SP3 : S_SE3;
      end
      S_SP3, S_SE3: begin
        res.done_res = 1'b1;
        res.error    = (phase == S_SE3);
        phase_next   = S_IDLE;
      end
      default: phase_next = S_IDLE;
    endcase

    if (load) begin
      shift_reg_next = load_byte;
      bit_count_next = '0;
      stage_next     = load_stage;
      phase_next     = S_TXL;
    end

    res.busy_res = (phase_next != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= S_IDLE;
      stage           <= STG_ADDRW;
      bit_count       <= '0;
      shift_reg       <= '0;
      bytes_left      <= '0;
      ack_cnt         <= '0;
      held_req_type   <= 1'b0;
      held_register   <= '0;
      held_write_data <= '0;
    end else if (step) begin
      phase           <= phase_next;
      stage           <= stage_next;
      bit_count       <= bit_count_next;
      shift_reg       <= shift_reg_next;
      bytes_left      <= bytes_left_next;
      ack_cnt         <= ack_cnt_next;
      held_req_type   <= held_req_type_next;
      held_register   <= held_register_next;
      held_write_data <= held_write_data_next;
    end
  end

endmodule

// File: hdl/i2cm_out_stage.sv
// Result register between the sequencer and the output channel.
// Depends on i2cm_pkg.
module i2cm_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cm_pkg::out_word_t word_in,
  output logic                push_ready,
  output logic                valid,
  input  logic                ready,
  output i2cm_pkg::out_word_t word_out
);
  import i2cm_pkg::*;

  assign push_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_ready) begin
      valid <= push;
    end
    if (push && push_ready) begin
      word_out <= word_in;
    end
  end

endmodule

// File: hdl/i2c_register_access_master.sv
// Top level of the I2C register access master: config, sequencer and result register.
// Depends on i2cm_pkg, i2cm_if, i2cm_cfg, i2cm_seq and i2cm_out_stage.
//
// Every input word is one half period of SCL and yields exactly one result word
// carrying the line levels for that half period. A word is taken in every cycle in
// which the result register is empty or being drained, so the sustained rate is one
// word per clock; each result appears in the cycle after its word is accepted, held in a
// single output register. Write the configuration registers only while no command runs.
module i2c_register_access_master #(
  parameter int MaxReadLen = i2cm_pkg::MAX_READ_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  i2cm_in_if.sink                         ticks,
  i2cm_out_if.source                      results,
  input  logic                            cfg_wr_en,
  input  i2cm_pkg::cfg_idx_t              cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  cfg_t      cfg;
  in_word_t  tick;
  out_word_t step_res;
  out_word_t res_q;
  logic      push_ready;
  logic      step;

  assign tick.cmd_valid = ticks.cmd_valid;
  assign tick.req_type  = ticks.req_type;
  assign tick.reg_addr  = ticks.reg_addr;
  assign tick.wr_data   = ticks.wr_data;
  assign tick.rd_len    = ticks.rd_len;
  assign tick.sda_in    = ticks.sda_in;

  assign ticks.ready = push_ready;
  assign step        = ticks.valid && push_ready;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cm_seq #(.MaxReadLen(MaxReadLen)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .tick (tick),
    .cfg  (cfg),
    .res  (step_res)
  );

  i2cm_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (ticks.valid),
    .word_in    (step_res),
    .push_ready (push_ready),
    .valid      (results.valid),
    .ready      (results.ready),
    .word_out   (res_q)
  );

  assign results.scl      = res_q.scl;
  assign results.sda_low  = res_q.sda_low;
  assign results.rd_data  = res_q.rd_data;
  assign results.rd_valid = res_q.rd_valid;
  assign results.rd_last  = res_q.rd_last;
  assign results.done_res = res_q.done_res;
  assign results.error    = res_q.error;
  assign results.busy_res = res_q.busy_res;

endmodule

// File: hdl/i2cm_checker.sv
// Port-level checks for the I2C register access master, bound to the top level.
// Depends on i2c_register_access_master and i2cm_pkg.
module i2cm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        scl,
  input logic                        sda_low,
  input logic [i2cm_pkg::BYTE_W-1:0] rd_data,
  input logic                        rd_valid,
  input logic                        rd_last,
  input logic                        done_res,
  input logic                        error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(rd_data) && $stable(scl)
      && $stable(sda_low) && $stable(done_res))
    else $error("stalled result word changed");

  a_rx_scl_high: assert property (@(posedge clk) disable iff (rst)
    res_valid && rd_valid |-> scl && !sda_low)
    else $error("received byte reported while SCL low or SDA driven");

  a_last_with_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && (rd_last || rd_data != '0) |-> rd_valid)
    else $error("read data or last flag without a received byte");

  a_error_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && error |-> done_res)
    else $error("error flag outside command completion");

  a_done_released: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> scl && !sda_low && !rd_valid)
    else $error("command completion without released bus");

endmodule

bind i2c_register_access_master i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .scl       (results.scl),
  .sda_low   (results.sda_low),
  .rd_data   (results.rd_data),
  .rd_valid  (results.rd_valid),
  .rd_last   (results.rd_last),
  .done_res  (results.done_res),
  .error     (results.error)
);
